>>> hdl/mat3i_pkg.sv
// ----------------------------------------------------------------------------
// mat3i_pkg
// Widths and shared types of the 3x3 adjugate matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mat3i_pkg;

  localparam int ELEM_W = 32;   // Q-format element
  localparam int N_ELEM = 9;    // elements per matrix
  localparam int PROD_W = 64;   // element * element
  localparam int COF_W  = 65;   // signed 2x2 cofactor
  localparam int CMAG_W = 64;   // cofactor magnitude
  localparam int TERM_W = 99;   // determinant accumulation
  localparam int DMAG_W = 96;   // determinant magnitude
  localparam int QB     = 34;   // quotient bits kept, bits above the 32-bit result show overflow

  typedef logic [N_ELEM-1:0][ELEM_W-1:0] mat_t;

  // travels alongside the divider lanes
  typedef struct packed {
    logic                  singular;
    logic [N_ELEM-1:0]     neg;
    logic [DMAG_W-1:0]     dmag;
    mat_t                  echo;
  } side_t;

  typedef struct packed {
    side_t                           side;
    logic [N_ELEM-1:0][CMAG_W-1:0]   cmag;
  } frt_out_t;

endpackage

>>> hdl/mat3i_ifs.sv
// ----------------------------------------------------------------------------
// mat3i channel interfaces
// Valid/ready channels for the matrix request and the inverse result.
// ----------------------------------------------------------------------------
interface mat3i_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [mat3i_pkg::ELEM_W-1:0] a_r0c0;
  logic signed [mat3i_pkg::ELEM_W-1:0] a_r0c1;
  logic signed [mat3i_pkg::ELEM_W-1:0] a_r0c2;
  logic signed [mat3i_pkg::ELEM_W-1:0] a_r1c0;
  logic signed [mat3i_pkg::ELEM_W-1:0] a_r1c1;
  logic signed [mat3i_pkg::ELEM_W-1:0] a_r1c2;
  logic signed [mat3i_pkg::ELEM_W-1:0] a_r2c0;
  logic signed [mat3i_pkg::ELEM_W-1:0] a_r2c1;
  logic signed [mat3i_pkg::ELEM_W-1:0] a_r2c2;

  modport source (
    output valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2,
    input  ready
  );
  modport sink (
    input  valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2,
    output ready
  );
endinterface

interface mat3i_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mat3i_pkg::ELEM_W-1:0] q_r0c0;
  logic signed [mat3i_pkg::ELEM_W-1:0] q_r0c1;
  logic signed [mat3i_pkg::ELEM_W-1:0] q_r0c2;
  logic signed [mat3i_pkg::ELEM_W-1:0] q_r1c0;
  logic signed [mat3i_pkg::ELEM_W-1:0] q_r1c1;
  logic signed [mat3i_pkg::ELEM_W-1:0] q_r1c2;
  logic signed [mat3i_pkg::ELEM_W-1:0] q_r2c0;
  logic signed [mat3i_pkg::ELEM_W-1:0] q_r2c1;
  logic signed [mat3i_pkg::ELEM_W-1:0] q_r2c2;
  logic                               singular;
  logic                               saturated;

  modport source (
    output valid, q_r0c0, q_r0c1, q_r0c2, q_r1c0, q_r1c1, q_r1c2, q_r2c0, q_r2c1, q_r2c2,
           singular, saturated,
    input  ready
  );
  modport sink (
    input  valid, q_r0c0, q_r0c1, q_r0c2, q_r1c0, q_r1c1, q_r1c2, q_r2c0, q_r2c1, q_r2c2,
           singular, saturated,
    output ready
  );
endinterface

>>> hdl/mat3_inverse_adjugate_core.sv
// ----------------------------------------------------------------------------
// mat3_inverse_adjugate_core
// Pipeline: 6 front stages, 34 divider stages and 1 result register; the
// divider resolves one quotient bit per stage.
// Throughput: one matrix per cycle; every stage holds under output backpressure.
// Reset clears only the valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module mat3_inverse_adjugate_core #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  mat3i_in_if.sink   in_ch,
  mat3i_out_if.source out_ch
);

  mat3i_pkg::mat_t     in_mat;
  mat3i_pkg::frt_out_t frt_data;
  mat3i_pkg::mat_t     q_mat;
  logic                frt_valid;
  logic                frt_ready;

  assign in_mat[0] = in_ch.a_r0c0;
  assign in_mat[1] = in_ch.a_r0c1;
  assign in_mat[2] = in_ch.a_r0c2;
  assign in_mat[3] = in_ch.a_r1c0;
  assign in_mat[4] = in_ch.a_r1c1;
  assign in_mat[5] = in_ch.a_r1c2;
  assign in_mat[6] = in_ch.a_r2c0;
  assign in_mat[7] = in_ch.a_r2c1;
  assign in_mat[8] = in_ch.a_r2c2;

  mat3i_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mat    (in_mat),
    .out_valid (frt_valid),
    .out_ready (frt_ready),
    .out_data  (frt_data)
  );

  mat3i_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (frt_valid),
    .in_ready      (frt_ready),
    .in_data       (frt_data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_q         (q_mat),
    .out_singular  (out_ch.singular),
    .out_saturated (out_ch.saturated)
  );

  assign out_ch.q_r0c0 = q_mat[0];
  assign out_ch.q_r0c1 = q_mat[1];
  assign out_ch.q_r0c2 = q_mat[2];
  assign out_ch.q_r1c0 = q_mat[3];
  assign out_ch.q_r1c1 = q_mat[4];
  assign out_ch.q_r1c2 = q_mat[5];
  assign out_ch.q_r2c0 = q_mat[6];
  assign out_ch.q_r2c1 = q_mat[7];
  assign out_ch.q_r2c2 = q_mat[8];

endmodule

>>> hdl/mat3i_front.sv
// ----------------------------------------------------------------------------
// mat3i_front
// Six-stage front end: cofactor products, cofactors, determinant partial
// products, terms, determinant sum, then signs and magnitudes for division.
// ----------------------------------------------------------------------------
module mat3i_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mat3i_pkg::mat_t     in_mat,
  output logic                out_valid,
  input  logic                out_ready,
  output mat3i_pkg::frt_out_t out_data
);

  localparam int NS = 6;
  localparam int N  = mat3i_pkg::N_ELEM;
  localparam int TW = mat3i_pkg::TERM_W;
  localparam int DW = mat3i_pkg::DMAG_W;
  localparam int CW = mat3i_pkg::COF_W;
  localparam int MW = mat3i_pkg::CMAG_W;
  localparam int PW = mat3i_pkg::PROD_W;
  localparam int EW = mat3i_pkg::ELEM_W;
  localparam int LO_W = 33;                // low slice of a cofactor
  localparam int PL_W = EW + LO_W + 1;     // element * unsigned low slice

  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  // stage payloads
  logic signed [PW-1:0]   pp1_r [N];
  logic signed [PW-1:0]   ps1_r [N];
  mat3i_pkg::mat_t        echo1_r;
  logic signed [CW-1:0]   cof2_r [N];
  mat3i_pkg::mat_t        echo2_r;
  logic signed [PL_W-1:0] pl3_r [3];
  logic signed [PW-1:0]   ph3_r [3];
  logic signed [CW-1:0]   cof3_r [N];
  mat3i_pkg::mat_t        echo3_r;
  logic [TW-1:0]          term4_r [3];
  logic signed [CW-1:0]   cof4_r [N];
  mat3i_pkg::mat_t        echo4_r;
  logic [TW-1:0]          det5_r;
  logic signed [CW-1:0]   cof5_r [N];
  mat3i_pkg::mat_t        echo5_r;
  mat3i_pkg::frt_out_t    out_r;

  logic signed [PW-1:0]   pp_nxt [N];
  logic signed [PW-1:0]   ps_nxt [N];
  logic signed [CW-1:0]   cof_nxt [N];
  logic signed [PL_W-1:0] pl_nxt [3];
  logic signed [PW-1:0]   ph_nxt [3];
  logic [TW-1:0]          term_nxt [3];
  logic [TW-1:0]          det_nxt;
  logic [TW-1:0]          det_neg;
  mat3i_pkg::frt_out_t    out_nxt;

  // ready chain: a stage takes data when empty or when it is moving on
  assign en[NS-1] = !v_r[NS-1] || out_ready;
  genvar gk;
  generate
    for (gk = 0; gk < NS-1; gk++) begin : g_en
      assign en[gk] = !v_r[gk] || en[gk+1];
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // cyclic indexing gives the signed cofactor directly
  genvar gr, gc;
  generate
    for (gr = 0; gr < 3; gr++) begin : g_row
      for (gc = 0; gc < 3; gc++) begin : g_col
        localparam int K  = gr*3 + gc;
        localparam int R1 = (gr+1) % 3;
        localparam int R2 = (gr+2) % 3;
        localparam int C1 = (gc+1) % 3;
        localparam int C2 = (gc+2) % 3;
        assign pp_nxt[K]  = $signed(in_mat[R1*3+C1]) * $signed(in_mat[R2*3+C2]);
        assign ps_nxt[K]  = $signed(in_mat[R1*3+C2]) * $signed(in_mat[R2*3+C1]);
        assign cof_nxt[K] = $signed({pp1_r[K][PW-1], pp1_r[K]}) -
                            $signed({ps1_r[K][PW-1], ps1_r[K]});
      end
    end

    // row-0 expansion, cofactor split into a signed high and unsigned low part
    for (gc = 0; gc < 3; gc++) begin : g_det
      assign pl_nxt[gc] = $signed(echo2_r[gc]) * $signed({1'b0, cof2_r[gc][LO_W-1:0]});
      assign ph_nxt[gc] = $signed(echo2_r[gc]) * $signed(cof2_r[gc][CW-1:LO_W]);
      assign term_nxt[gc] = ({{(TW-PW){ph3_r[gc][PW-1]}}, ph3_r[gc]} << LO_W) +
                            {{(TW-PL_W){pl3_r[gc][PL_W-1]}}, pl3_r[gc]};
    end
  endgenerate

  assign det_nxt = term4_r[0] + term4_r[1] + term4_r[2];
  assign det_neg = ~det5_r + {{(TW-1){1'b0}}, 1'b1};

  always_comb begin
    logic [CW-1:0] cf;
    logic [CW-1:0] cfn;
    out_nxt.side.singular = (det5_r == '0);
    out_nxt.side.dmag     = det5_r[TW-1] ? det_neg[DW-1:0] : det5_r[DW-1:0];
    out_nxt.side.echo     = echo5_r;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        // adjugate is the transposed cofactor matrix
        cf  = cof5_r[c*3+r];
        cfn = ~cf + {{(CW-1){1'b0}}, 1'b1};
        out_nxt.side.neg[r*3+c] = cf[CW-1] ^ det5_r[TW-1];
        out_nxt.cmag[r*3+c]     = cf[CW-1] ? cfn[MW-1:0] : cf[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp1_r   <= pp_nxt;
      ps1_r   <= ps_nxt;
      echo1_r <= in_mat;
    end
    if (en[1]) begin
      cof2_r  <= cof_nxt;
      echo2_r <= echo1_r;
    end
    if (en[2]) begin
      pl3_r   <= pl_nxt;
      ph3_r   <= ph_nxt;
      cof3_r  <= cof2_r;
      echo3_r <= echo2_r;
    end
    if (en[3]) begin
      term4_r <= term_nxt;
      cof4_r  <= cof3_r;
      echo4_r <= echo3_r;
    end
    if (en[4]) begin
      det5_r  <= det_nxt;
      cof5_r  <= cof4_r;
      echo5_r <= echo4_r;
    end
    if (en[5]) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> hdl/mat3i_div.sv
// ----------------------------------------------------------------------------
// mat3i_div
// Nine-lane pipelined restoring divider, one quotient bit per stage, followed
// by the saturating sign fix-up and the result register.
// ----------------------------------------------------------------------------
module mat3i_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mat3i_pkg::frt_out_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mat3i_pkg::mat_t     out_q,
  output logic                out_singular,
  output logic                out_saturated
);

  localparam int QB = mat3i_pkg::QB;
  localparam int N  = mat3i_pkg::N_ELEM;
  localparam int DW = mat3i_pkg::DMAG_W;
  localparam int EW = mat3i_pkg::ELEM_W;
  localparam int NW = mat3i_pkg::CMAG_W + 2*FRAC_BITS;
  localparam int RW = (NW > DW + QB) ? NW : DW + QB;
  localparam logic [QB-1:0] POS_LIM = QB'(64'h0000_0000_7FFF_FFFF);
  localparam logic [QB-1:0] NEG_LIM = QB'(64'h0000_0000_8000_0000);
  localparam logic [EW-1:0] POS_SAT = EW'(64'h7FFF_FFFF);
  localparam logic [EW-1:0] NEG_SAT = EW'(64'h8000_0000);

  logic [QB-1:0]         v_r;
  logic [QB:0]           en;
  mat3i_pkg::side_t      side_r [QB];
  logic [RW-1:0]         rem_r  [QB-1][N];
  logic [QB-1:0]         q_r    [QB][N];

  logic                  out_valid_r;
  mat3i_pkg::mat_t       out_q_r;
  logic                  out_sing_r;
  logic                  out_sat_r;

  assign en[QB]        = !out_valid_r || out_ready;
  assign in_ready      = en[0];
  assign out_valid     = out_valid_r;
  assign out_q         = out_q_r;
  assign out_singular  = out_sing_r;
  assign out_saturated = out_sat_r;

  genvar gk, gl;
  generate
    for (gk = 0; gk < QB; gk++) begin : g_stage
      localparam int B = QB - 1 - gk;   // quotient bit decided here
      mat3i_pkg::side_t side_in;
      logic             v_in;
      logic [RW-1:0]    dsh;

      assign en[gk] = !v_r[gk] || en[gk+1];

      if (gk == 0) begin : g_head
        assign side_in = in_data.side;
        assign v_in    = in_valid;
      end else begin : g_body
        assign side_in = side_r[gk-1];
        assign v_in    = v_r[gk-1];
      end

      assign dsh = {{(RW-DW){1'b0}}, side_in.dmag} << B;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[gk] <= 1'b0;
        end else if (en[gk]) begin
          v_r[gk] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en[gk]) begin
          side_r[gk] <= side_in;
        end
      end

      for (gl = 0; gl < N; gl++) begin : g_lane
        logic [RW-1:0] rem_in;
        logic [QB-1:0] q_in;
        logic [RW:0]   diff;
        logic          take;

        if (gk == 0) begin : g_num
          assign rem_in = {{(RW-mat3i_pkg::CMAG_W){1'b0}}, in_data.cmag[gl]} << (2*FRAC_BITS);
          assign q_in   = '0;
        end else begin : g_prev
          assign rem_in = rem_r[gk-1][gl];
          assign q_in   = q_r[gk-1][gl];
        end

        assign diff = {1'b0, rem_in} - {1'b0, dsh};
        assign take = !diff[RW];

        always_ff @(posedge clk) begin
          if (en[gk]) begin
            q_r[gk][gl] <= q_in | ({{(QB-1){1'b0}}, take} << B);
          end
        end

        // the last step needs no remainder
        if (gk < QB-1) begin : g_rem
          always_ff @(posedge clk) begin
            if (en[gk]) begin
              rem_r[gk][gl] <= take ? diff[RW-1:0] : rem_in;
            end
          end
        end
      end
    end
  endgenerate

  // sign, saturation and singular bypass
  mat3i_pkg::mat_t q_nxt;
  logic            sat_nxt;

  always_comb begin
    logic [QB-1:0] qm;
    logic [QB-1:0] qn;
    logic          ng;
    logic          clip;
    sat_nxt = 1'b0;
    for (int l = 0; l < N; l++) begin
      qm   = q_r[QB-1][l];
      qn   = ~qm + {{(QB-1){1'b0}}, 1'b1};
      ng   = side_r[QB-1].neg[l];
      clip = ng ? (qm > NEG_LIM) : (qm > POS_LIM);
      if (side_r[QB-1].singular) begin
        q_nxt[l] = side_r[QB-1].echo[l];
      end else if (clip) begin
        q_nxt[l] = ng ? NEG_SAT : POS_SAT;
      end else begin
        q_nxt[l] = ng ? qn[EW-1:0] : qm[EW-1:0];
      end
      sat_nxt = sat_nxt | (clip & !side_r[QB-1].singular);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en[QB]) begin
      out_valid_r <= v_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[QB]) begin
      out_q_r    <= q_nxt;
      out_sing_r <= side_r[QB-1].singular;
      out_sat_r  <= sat_nxt;
    end
  end

endmodule

>>> dv/mat3i_inverse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat3i_inverse_checker
// Watches the matrix request and inverse result channels, works out each
// inverse from the accepted request, and compares results in order.
// ----------------------------------------------------------------------------
module mat3i_inverse_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  mat3i_in_if.source  in_mon,
  mat3i_out_if.sink   out_mon,
  output int          fail_count,
  output int          pending,
  output int          n_singular,
  output int          n_saturated,
  output int          n_results
);

  typedef struct {
    logic [mat3i_pkg::ELEM_W-1:0] q [9];
    logic                         singular;
    logic                         saturated;
  } inverse_t;

  inverse_t inverse_q[$];

  function automatic inverse_t invert_matrix(logic signed [mat3i_pkg::ELEM_W-1:0] a [9]);
    inverse_t res;
    logic signed [127:0] cof [3][3];
    logic signed [127:0] det;
    logic signed [127:0] num, quo;
    int r1, r2, c1, c2;
    det = 0;
    res.saturated = 1'b0;
    for (int r = 0; r < 3; r++) begin
      r1 = (r + 1) % 3;
      r2 = (r + 2) % 3;
      for (int c = 0; c < 3; c++) begin
        c1 = (c + 1) % 3;
        c2 = (c + 2) % 3;
        cof[r][c] = 128'(a[r1*3+c1]) * 128'(a[r2*3+c2])
                  - 128'(a[r1*3+c2]) * 128'(a[r2*3+c1]);
      end
    end
    for (int c = 0; c < 3; c++) det += 128'(a[c]) * cof[0][c];
    if (det == 0) begin
      for (int i = 0; i < 9; i++) res.q[i] = a[i];
      res.singular = 1'b1;
      return res;
    end
    res.singular = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        // |cof| < 2^64, shifted by 2F <= 48 fits; signed division truncates
        num = cof[c][r] <<< (2 * FRAC_BITS);
        quo = num / det;
        if (quo > 128'sh7FFFFFFF) begin
          res.q[r*3+c] = 32'h7FFFFFFF;
          res.saturated = 1'b1;
        end else if (quo < -128'sh80000000) begin
          res.q[r*3+c] = 32'h80000000;
          res.saturated = 1'b1;
        end else begin
          res.q[r*3+c] = quo[31:0];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    logic signed [mat3i_pkg::ELEM_W-1:0] a [9];
    logic [mat3i_pkg::ELEM_W-1:0] got [9];
    inverse_t want;
    if (!rst_n) begin
      fail_count  <= 0;
      n_singular  <= 0;
      n_saturated <= 0;
      n_results   <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        a = '{in_mon.a_r0c0, in_mon.a_r0c1, in_mon.a_r0c2,
              in_mon.a_r1c0, in_mon.a_r1c1, in_mon.a_r1c2,
              in_mon.a_r2c0, in_mon.a_r2c1, in_mon.a_r2c2};
        inverse_q.push_back(invert_matrix(a));
      end
      if (out_mon.valid && out_mon.ready) begin
        n_results <= n_results + 1;
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected inverse result, none pending", $time);
          fail_count <= fail_count + 1;
        end else begin
          want = inverse_q.pop_front();
          got = '{out_mon.q_r0c0, out_mon.q_r0c1, out_mon.q_r0c2,
                  out_mon.q_r1c0, out_mon.q_r1c1, out_mon.q_r1c2,
                  out_mon.q_r2c0, out_mon.q_r2c1, out_mon.q_r2c2};
          n_singular  <= n_singular + want.singular;
          n_saturated <= n_saturated + want.saturated;
          if (got != want.q || out_mon.singular !== want.singular
              || out_mon.saturated !== want.saturated) begin
            fail_count <= fail_count + 1;
            for (int i = 0; i < 9; i++)
              if (got[i] !== want.q[i])
                $display("%0t: q[r%0dc%0d] expected %h actual %h", $time,
                         i / 3, i % 3, want.q[i], got[i]);
            if (out_mon.singular !== want.singular)
              $display("%0t: singular expected %b actual %b", $time,
                       want.singular, out_mon.singular);
            if (out_mon.saturated !== want.saturated)
              $display("%0t: saturated expected %b actual %b", $time,
                       want.saturated, out_mon.saturated);
          end
        end
      end
    end
    pending <= inverse_q.size();
  end
endmodule

>>> dv/mat3_inverse_adjugate_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mat3_inverse_adjugate_core_test
// Drives directed and random 3x3 matrices through the inverse core with random
// request gaps and result stalls; a checker predicts and compares each inverse.
// ----------------------------------------------------------------------------
module mat3_inverse_adjugate_core_test;

  localparam int  N_RANDOM  = 1130;
  localparam int  LATENCY   = 41;
  localparam int  MAX_CYCLE = 200000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic clk;
  logic rst_n;
  int   cycle;
  int   fail_count, pending, n_singular, n_saturated, n_results;
  bit   calm;

  mat3i_in_if  in_ch();
  mat3i_out_if out_ch();

  mat3_inverse_adjugate_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mat3i_inverse_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .n_singular  (n_singular),
    .n_saturated (n_saturated),
    .n_results   (n_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle > MAX_CYCLE) begin
        $display("timeout at cycle %0d, %0d results pending", cycle, pending);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // result-side stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  task automatic send_matrix(logic [31:0] m [9]);
    while (!calm && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.a_r0c0 <= m[0]; in_ch.a_r0c1 <= m[1]; in_ch.a_r0c2 <= m[2];
    in_ch.a_r1c0 <= m[3]; in_ch.a_r1c1 <= m[4]; in_ch.a_r1c2 <= m[5];
    in_ch.a_r2c0 <= m[6]; in_ch.a_r2c1 <= m[7]; in_ch.a_r2c2 <= m[8];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(5))
      0:       return $urandom();
      1:       return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0} ^ $urandom_range(3);
      2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(signed'($urandom_range(8 * ONE)) - signed'(4 * ONE));
    endcase
  endfunction

  initial begin
    logic [31:0] m [9];
    logic [31:0] k;
    calm = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.a_r0c0, in_ch.a_r0c1, in_ch.a_r0c2, in_ch.a_r1c0, in_ch.a_r1c1,
     in_ch.a_r1c2, in_ch.a_r2c0, in_ch.a_r2c1, in_ch.a_r2c2} = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: identity, scaled, zero, extremes, rank-deficient, tiny det
    m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};                        send_matrix(m);
    m = '{2*ONE, 0, 0, 0, -4*ONE, 0, 0, 0, ONE/2};                 send_matrix(m);
    m = '{default: 0};                                             send_matrix(m);
    m = '{default: 32'h7FFF_FFFF};                                 send_matrix(m);
    m = '{default: 32'h8000_0000};                                 send_matrix(m);
    m = '{default: 32'hFFFF_FFFF};                                 send_matrix(m);
    m = '{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF};
    send_matrix(m);
    m = '{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000};
    send_matrix(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                              send_matrix(m);
    m = '{32'hFFFF_FFFF, 0, 0, 0, 1, 0, 0, 0, 1};                  send_matrix(m);
    m = '{ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE};
    send_matrix(m);
    m = '{ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 5*ONE, 6*ONE, 0};      send_matrix(m);
    m = '{0, ONE, 0, 0, 0, ONE, ONE, 0, 0};                        send_matrix(m);
    m = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1};
    send_matrix(m);
    m = '{1, 1, 0, 1, 32'hFFFF_FFFF, 0, 0, 0, 32'h8000_0000};      send_matrix(m);

    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 400 && n < 550);
      for (int i = 0; i < 9; i++) m[i] = rand_elem();
      // force some singular matrices: copy, scale or zero a row
      case ($urandom_range(9))
        0: for (int i = 0; i < 3; i++) m[3 + i] = m[i];
        1: for (int i = 0; i < 3; i++) m[6 + i] = 0;
        2: begin
          k = $urandom_range(1) ? 32'hFFFF_FFFF : 2;
          for (int i = 0; i < 3; i++) m[6 + i] = m[i] * k;
        end
        default: ;
      endcase
      send_matrix(m);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d inverses checked: %0d singular, %0d saturated",
             n_results, n_singular, n_saturated);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
